// ===== hdl/circular_deque_engine_top_macros.svh =====
// ----------------------------------------------------------------------------
// circular_deque_engine_top_macros
// Assertion shorthands shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ENGINE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CDQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, sampled on clk, off during reset
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int CDQ_DEPTH = 64;
	localparam int CDQ_DATA_W = 32;
	localparam int CDQ_CAP_W = 7;
	localparam int CDQ_OCC_W = 7;
	localparam logic [CDQ_CAP_W-1:0] CDQ_CAP_RESET = 7'd64;
	localparam logic [CDQ_DATA_W-1:0] CDQ_EMPTY_READ = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_REAR  = 3'd1,
		ACT_DEL_FRONT = 3'd2,
		ACT_DEL_REAR  = 3'd3,
		ACT_QUERY     = 3'd4
	} act_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic                  a_push; // front-ordered row shifts toward the rear
		logic                  a_pop;  // front-ordered row shifts toward the front
		logic                  a_put;  // front-ordered row writes at the count
		logic                  b_push; // rear-ordered row shifts away from the rear
		logic                  b_pop;  // rear-ordered row shifts toward the rear
		logic                  b_put;  // rear-ordered row writes at the count
		logic [CDQ_DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One position of the deque: a slot in the front-ordered row and a slot in
// the rear-ordered row, each loaded from a neighbor or by a direct write.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cell
	import cdq_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 7
) (
	input  wire logic                  clk,
	input  wire cell_ctl_t             ctl,
	input  wire logic [CNT_W-1:0]      cnt,
	input  wire logic [CDQ_DATA_W-1:0] a_prev,
	input  wire logic [CDQ_DATA_W-1:0] a_next,
	input  wire logic [CDQ_DATA_W-1:0] b_prev,
	input  wire logic [CDQ_DATA_W-1:0] b_next,
	output logic      [CDQ_DATA_W-1:0] a_q,
	output logic      [CDQ_DATA_W-1:0] b_q
);

	logic at_cnt;

	assign at_cnt = (cnt == CNT_W'(IDX));

	always_ff @(posedge clk) begin
		priority if (ctl.a_push) begin
			a_q <= a_prev;
		end else if (ctl.a_pop) begin
			a_q <= a_next;
		end else if (ctl.a_put && at_cnt) begin
			a_q <= ctl.value;
		end else begin
			a_q <= a_q;
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.b_push) begin
			b_q <= b_prev;
		end else if (ctl.b_pop) begin
			b_q <= b_next;
		end else if (ctl.b_put && at_cnt) begin
			b_q <= ctl.value;
		end else begin
			b_q <= b_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/circular_deque_engine_top.sv =====
// A result is registered in the cycle after its action is accepted.
// One action per cycle; every action is at most one shift and one indexed
//   write in the rows of cells, so nothing iterates.
// The input waits only while a finished result is held by a stalled output.
// Reset clears the count, the output valid and sets capacity to 64; slot
//   contents are not reset and are only read after being written.
`default_nettype none

// ----------------------------------------------------------------------------
// circular_deque_engine_top
// Bounded double-ended queue of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
module circular_deque_engine_top
	import cdq_pkg::*;
#(
	parameter int DEPTH = CDQ_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// action channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   action,
	input  wire logic signed [CDQ_DATA_W-1:0] value,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              ok,
	output logic signed [CDQ_DATA_W-1:0]      front_value,
	output logic signed [CDQ_DATA_W-1:0]      rear_value,
	output logic                              is_empty,
	output logic                              is_full,
	output logic [CDQ_OCC_W-1:0]              occupancy,
	// capacity write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CDQ_CAP_W-1:0]         capacity
);

	// count runs 0..DEPTH; compares happen at the wider of count and capacity
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CDQ_CAP_W) ? CNT_W : CDQ_CAP_W;

	// Two rows hold the same entries: row A front first, row B rear first.
	// Front inserts shift A and write B at the count, front deletes only shift A;
	// rear ops do the opposite. Front is always A[0], rear is always B[0].
	logic [CDQ_DATA_W-1:0] a_w [DEPTH];
	logic [CDQ_DATA_W-1:0] b_w [DEPTH];

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic [CDQ_CAP_W-1:0] cap_q;
	logic [CMP_W-1:0]     eff_cap;
	logic                 full_now;
	logic                 empty_now;
	logic                 accept;
	logic                 ok_nxt;
	logic [CDQ_DATA_W-1:0] front_sel;
	logic [CDQ_DATA_W-1:0] rear_sel;
	logic [CMP_W-1:0]     count_ext;
	cell_ctl_t            ctl;
	act_t                 act;

	// payload registers of the result beat
	logic                  ok_q;
	logic [CDQ_DATA_W-1:0] front_q;
	logic [CDQ_DATA_W-1:0] rear_q;
	logic                  empty_q;
	logic                  full_q;
	logic [CDQ_OCC_W-1:0]  occ_q;
	logic                  out_valid_q;

	assign act       = act_t'(action);
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// capacity saturates at the store depth
	assign eff_cap   = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
	assign full_now  = CMP_W'(count_q) >= eff_cap;
	assign empty_now = (count_q == '0);

	// decode the action into cell commands and the post-action view
	always_comb begin
		ctl       = '0;
		ctl.value = value;
		ok_nxt    = 1'b0;
		count_nxt = count_q;
		front_sel = a_w[0];
		rear_sel  = b_w[0];
		unique case (act)
			ACT_INS_FRONT: begin
				if (!full_now) begin
					ctl.a_push = accept;
					ctl.b_put  = accept;
					ok_nxt     = 1'b1;
					count_nxt  = count_q + CNT_W'(1);
					front_sel  = value;
					if (empty_now) begin
						rear_sel = value;
					end
				end
			end
			ACT_INS_REAR: begin
				if (!full_now) begin
					ctl.b_push = accept;
					ctl.a_put  = accept;
					ok_nxt     = 1'b1;
					count_nxt  = count_q + CNT_W'(1);
					rear_sel   = value;
					if (empty_now) begin
						front_sel = value;
					end
				end
			end
			ACT_DEL_FRONT: begin
				if (!empty_now) begin
					ctl.a_pop = accept;
					ok_nxt    = 1'b1;
					count_nxt = count_q - CNT_W'(1);
					front_sel = a_w[1];
				end
			end
			ACT_DEL_REAR: begin
				if (!empty_now) begin
					ctl.b_pop = accept;
					ok_nxt    = 1'b1;
					count_nxt = count_q - CNT_W'(1);
					rear_sel  = b_w[1];
				end
			end
			ACT_QUERY: begin
				ok_nxt = 1'b1;
			end
			default: begin
				// undefined codes read like a query but report failure
				ok_nxt = 1'b0;
			end
		endcase
	end

	assign count_ext = CMP_W'(count_nxt);

	// row of cells; the ends take the incoming value and zero fill
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [CDQ_DATA_W-1:0] a_prev;
		logic [CDQ_DATA_W-1:0] b_prev;
		logic [CDQ_DATA_W-1:0] a_next;
		logic [CDQ_DATA_W-1:0] b_next;

		if (i == 0) begin : g_head
			assign a_prev = value;
			assign b_prev = value;
		end else begin : g_body
			assign a_prev = a_w[i-1];
			assign b_prev = b_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign a_next = '0;
			assign b_next = '0;
		end else begin : g_link
			assign a_next = a_w[i+1];
			assign b_next = b_w[i+1];
		end

		cdq_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.cnt    (count_q),
			.a_prev (a_prev),
			.a_next (a_next),
			.b_prev (b_prev),
			.b_next (b_next),
			.a_q    (a_w[i]),
			.b_q    (b_w[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= CDQ_CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nxt;
			end
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok_nxt;
			empty_q <= (count_nxt == '0);
			full_q  <= count_ext >= eff_cap;
			occ_q   <= count_ext[CDQ_OCC_W-1:0];
			front_q <= (count_nxt == '0) ? CDQ_EMPTY_READ : front_sel;
			rear_q  <= (count_nxt == '0) ? CDQ_EMPTY_READ : rear_sel;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign front_value = front_q;
	assign rear_value  = rear_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;
	assign occupancy   = occ_q;

endmodule

`default_nettype wire

// ===== hdl/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_engine_top_macros.svh"

module cdq_checker
	import cdq_pkg::*;
(
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [CDQ_DATA_W-1:0] front_value,
	input wire logic signed [CDQ_DATA_W-1:0] rear_value,
	input wire logic                         is_empty,
	input wire logic [CDQ_OCC_W-1:0]         occupancy
);

	// a stalled result holds
	`CDQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(front_value) && $stable(rear_value) && $stable(occupancy))

	// every accepted action yields a result beat
	`CDQ_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid)

	// an idle output never blocks the input
	`CDQ_ASSERT_NOW(a_idle_ready, !out_valid, in_ready)

	// an empty deque reads minus one on both ends
	`CDQ_ASSERT_NOW(a_empty_read, out_valid && is_empty,
		(front_value == -32'sd1) && (rear_value == -32'sd1))

endmodule

bind circular_deque_engine_top cdq_checker u_cdq_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for circular_deque_engine_top: a directed table, then
// biased random fill/drain phases under several capacities, with bursty
// input, patterned output stalls and a scoreboard fed by a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	// action codes the package leaves undefined; the block treats them as a
	// query that reports failure
	localparam logic [2:0] ACT_RSVD_A = 3'd5;
	localparam logic [2:0] ACT_RSVD_B = 3'd6;
	localparam logic [2:0] ACT_RSVD_C = 3'd7;

	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NONE    = CDQ_EMPTY_READ;

	localparam int NUM_PHASES     = 10;
	localparam int ITEMS_PER_PHASE = 158;
	localparam int IDLE_LIMIT     = 1000; // cycles with no beat on any channel
	localparam int DRAIN_CYCLES   = 4;    // extra idle clocks at the end of the run

	// one result beat
	typedef struct packed {
		logic        ok;
		logic [31:0] front;
		logic [31:0] rear;
		logic        empty;
		logic        full;
		logic [6:0]  occ;
	} deque_result_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		logic [2:0]    act;
		logic [31:0]   val;
		logic          typed;
		deque_result_t res;
	} stim_row_t;

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = ACT_QUERY;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        ok;
	logic [31:0] front_value;
	logic [31:0] rear_value;
	logic        is_empty;
	logic        is_full;
	logic [6:0]  occupancy;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  capacity = CDQ_CAP_RESET;

	circular_deque_engine_top #(
		.DEPTH(CDQ_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.front_value(front_value),
		.rear_value (rear_value),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.occupancy  (occupancy),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (capacity)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: our own copy of the ring, its head, the fill count and
	// the capacity register
	// ------------------------------------------------------------------------
	logic [31:0] ring [CDQ_DEPTH];
	int          head = 0;
	int          held = 0;
	logic [6:0]  cap_reg = CDQ_CAP_RESET;

	deque_result_t pending_results [$];
	stim_row_t     dir_rows [$];

	int err_count   = 0;
	int n_actions   = 0;
	int n_results   = 0;
	int n_refused   = 0;
	int n_cfg       = 0;
	int peak_held   = 0;
	int n_full_hits = 0;

	// sender burst shaping and receiver stall mode, changed per phase
	int burst_left = 0;
	int gap_max    = 0;
	int rx_mode    = 0;
	int rx_cycle   = 0;

	// capacity above the store depth behaves as the depth
	function automatic int eff_capacity();
		return (int'(cap_reg) > CDQ_DEPTH) ? CDQ_DEPTH : int'(cap_reg);
	endfunction

	// Apply one action to the predictor and return the result it implies.
	function automatic deque_result_t predict_deque(logic [2:0] act, logic [31:0] val);
		deque_result_t r;
		int lim;
		lim = eff_capacity();
		r.ok = 1'b0;
		case (act)
			ACT_INS_FRONT: begin
				if (held < lim) begin
					head = (head + CDQ_DEPTH - 1) % CDQ_DEPTH;
					ring[head] = val;
					held++;
					r.ok = 1'b1;
				end
			end
			ACT_INS_REAR: begin
				if (held < lim) begin
					ring[(head + held) % CDQ_DEPTH] = val;
					held++;
					r.ok = 1'b1;
				end
			end
			ACT_DEL_FRONT: begin
				if (held != 0) begin
					head = (head + 1) % CDQ_DEPTH;
					held--;
					r.ok = 1'b1;
				end
			end
			ACT_DEL_REAR: begin
				if (held != 0) begin
					held--;
					r.ok = 1'b1;
				end
			end
			ACT_QUERY: r.ok = 1'b1;
			default: r.ok = 1'b0; // unknown code: query that fails
		endcase
		// only slots written by inserts are ever read here
		r.front = (held != 0) ? ring[head] : NONE;
		r.rear  = (held != 0) ? ring[(head + held - 1) % CDQ_DEPTH] : NONE;
		r.empty = (held == 0);
		r.full  = (held >= lim);
		r.occ   = 7'(held);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH result %0d: %s", $realtime, n_results, msg);
		err_count++;
	endtask

	// ------------------------------------------------------------------------
	// Sender: one action beat. Called just after a rising edge; returns at the
	// edge where the beat is taken, with the expectation queued.
	// ------------------------------------------------------------------------
	task automatic send_action(input logic [2:0] act, input logic [31:0] val,
		input logic use_typed, input deque_result_t typed_res);
		int gap;
		deque_result_t pred;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		action   <= act;
		value    <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_deque(act, val);
		pending_results.push_back(use_typed ? typed_res : pred);
		n_actions++;
		if (!pred.ok) n_refused++;
		if (pred.full && pred.ok && (act == ACT_INS_FRONT || act == ACT_INS_REAR))
			n_full_hits++;
		if (held > peak_held) peak_held = held;
	endtask

	// Capacity write, only with the block idle: sender low, nothing pending.
	task automatic set_capacity(input logic [6:0] cap);
		while (pending_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		capacity  <= cap;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = cap;
		n_cfg++;
	endtask

	// ------------------------------------------------------------------------
	// Receiver stall patterns:
	//   0 always ready, 1 coin flip, 2 fixed periodic duty, 3 sparse
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rx_cycle++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ((rx_cycle % 7) < 2);
			default: out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// ------------------------------------------------------------------------
	// Scoreboard: every result beat against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok)
					report_mismatch($sformatf("ok got %b want %b", ok, want.ok));
				if (front_value !== want.front)
					report_mismatch($sformatf("front_value got %h want %h",
						front_value, want.front));
				if (rear_value !== want.rear)
					report_mismatch($sformatf("rear_value got %h want %h",
						rear_value, want.rear));
				if (is_empty !== want.empty)
					report_mismatch($sformatf("is_empty got %b want %b",
						is_empty, want.empty));
				if (is_full !== want.full)
					report_mismatch($sformatf("is_full got %b want %b",
						is_full, want.full));
				if (occupancy !== want.occ)
					report_mismatch($sformatf("occupancy got %0d want %0d",
						occupancy, want.occ));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long with no beat on any channel ends the run
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready) || !arst_n)
				idle = 0;
			else
				idle++;
		end
		$display("[%0t] watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [6:0]  phase_caps [NUM_PHASES];
		logic [2:0]  act;
		logic [31:0] val;
		int          roll;
		bit          filling;

		// 64 first to fill deep, then 3 so the count sits above the new
		// capacity, 0 where every insert fails, and the top of the field
		phase_caps = '{7'd64, 7'd3, 7'd0, 7'd1, 7'd127, 7'd64, 7'd2, 7'd100,
			7'd40, 7'($urandom_range(0, 127))};

		// directed table; expectations typed in where they are obvious
		dir_rows.push_back('{ACT_QUERY, 32'h0, 1'b1, '{1'b1, NONE, NONE, 1'b1, 1'b0, 7'd0}});
		dir_rows.push_back('{ACT_DEL_FRONT, 32'h0, 1'b1, '{1'b0, NONE, NONE, 1'b1, 1'b0, 7'd0}});
		dir_rows.push_back('{ACT_DEL_REAR, 32'h0, 1'b1, '{1'b0, NONE, NONE, 1'b1, 1'b0, 7'd0}});
		dir_rows.push_back('{ACT_RSVD_A, 32'h0, 1'b1, '{1'b0, NONE, NONE, 1'b1, 1'b0, 7'd0}});
		// front insert wraps the head from slot 0 to the top of the store
		dir_rows.push_back('{ACT_INS_FRONT, VAL_MIN, 1'b1,
			'{1'b1, VAL_MIN, VAL_MIN, 1'b0, 1'b0, 7'd1}});
		dir_rows.push_back('{ACT_INS_REAR, VAL_MAX, 1'b1,
			'{1'b1, VAL_MIN, VAL_MAX, 1'b0, 1'b0, 7'd2}});
		dir_rows.push_back('{ACT_INS_FRONT, 32'h0, 1'b1,
			'{1'b1, 32'h0, VAL_MAX, 1'b0, 1'b0, 7'd3}});
		dir_rows.push_back('{ACT_INS_REAR, NONE, 1'b1,
			'{1'b1, 32'h0, NONE, 1'b0, 1'b0, 7'd4}});
		dir_rows.push_back('{ACT_RSVD_B, 32'h1234_5678, 1'b1,
			'{1'b0, 32'h0, NONE, 1'b0, 1'b0, 7'd4}});
		dir_rows.push_back('{ACT_RSVD_C, VAL_MAX, 1'b1,
			'{1'b0, 32'h0, NONE, 1'b0, 1'b0, 7'd4}});
		// the rest checked by the predictor
		dir_rows.push_back('{ACT_INS_FRONT, 32'h5555_5555, 1'b0, '0});
		dir_rows.push_back('{ACT_INS_REAR, 32'hAAAA_AAAA, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_REAR, 32'hFFFF_FFFF, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_FRONT, 32'hFFFF_FFFF, 1'b0, '0});
		dir_rows.push_back('{ACT_QUERY, 32'hDEAD_BEEF, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_FRONT, 32'h0, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_FRONT, 32'h0, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_FRONT, 32'h0, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_REAR, 32'h0, 1'b0, '0});
		dir_rows.push_back('{ACT_INS_REAR, 32'h0000_0001, 1'b0, '0});
		dir_rows.push_back('{ACT_DEL_FRONT, 32'h0, 1'b0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset capacity, light idling on both sides
		gap_max = 2;
		rx_mode = 1;
		foreach (dir_rows[k])
			send_action(dir_rows[k].act, dir_rows[k].val, dir_rows[k].typed,
				dir_rows[k].res);
		in_valid <= 1'b0;

		// random phases: fill until full, drain until empty, repeat; some
		// noise of queries and unknown codes throughout
		for (int p = 0; p < NUM_PHASES; p++) begin
			burst_left = 0;
			// sender holds off here until every result is back
			set_capacity(phase_caps[p]);
			gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
			rx_mode = p % 4; // phase 0: no idling on either side
			filling = 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (held == 0)
					filling = 1'b1;
				else if (held >= eff_capacity())
					filling = 1'b0;
				roll = $urandom_range(0, 99);
				if (roll < 8)
					act = 3'($urandom_range(ACT_QUERY, ACT_RSVD_C));
				else if ((roll < 80) == filling)
					act = $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_REAR;
				else
					act = $urandom_range(0, 1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
				case ($urandom_range(0, 15))
					0: val = VAL_MIN;
					1: val = VAL_MAX;
					default: val = $urandom;
				endcase
				send_action(act, val, 1'b0, '0);
			end
			in_valid <= 1'b0;
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d actions (%0d refused), %0d results checked, %0d capacity writes",
			n_actions, n_refused, n_results, n_cfg);
		$display("Peak occupancy %0d, deque filled to capacity %0d times",
			peak_held, n_full_hits);
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque_engine_top.sv
hdl/cdq_checker.sv
tb/tb_top.sv
